// ===== rtl/sol_pkg.sv =====
`default_nettype none
package sol_pkg;

  localparam int SAMPLE_W = 24;
  localparam int CFG_W    = 24;
  localparam int CFG_AW   = 4;

  localparam logic [1:0] CMD_FRAME  = 2'd0;
  localparam logic [1:0] CMD_JUMP   = 2'd1;
  localparam logic [1:0] CMD_RAMP   = 2'd2;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  localparam logic [CFG_AW-1:0] REG_LGAIN   = 4'd0;
  localparam logic [CFG_AW-1:0] REG_RGAIN   = 4'd1;
  localparam logic [CFG_AW-1:0] REG_WIDTH   = 4'd2;
  localparam logic [CFG_AW-1:0] REG_MODE    = 4'd3;
  localparam logic [CFG_AW-1:0] REG_THR     = 4'd4;
  localparam logic [CFG_AW-1:0] REG_ATTACK  = 4'd5;
  localparam logic [CFG_AW-1:0] REG_RELEASE = 4'd6;
  localparam logic [CFG_AW-1:0] REG_VOLUME  = 4'd7;

  localparam int MODE_MONO   = 0;
  localparam int MODE_SWAP   = 1;
  localparam int MODE_LIMIT  = 2;
  localparam int MODE_BYPASS = 3;

  localparam logic [16:0] ONE16 = 17'd65536;
  localparam logic [24:0] ONE24 = 25'd16777216;

  typedef struct packed {
    logic [1:0]                 command;
    logic signed [SAMPLE_W-1:0] left_sample;
    logic signed [SAMPLE_W-1:0] right_sample;
    logic [16:0]                fade_target;
    logic [23:0]                ramp_frames;
  } in_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] left_out;
    logic signed [SAMPLE_W-1:0] right_out;
  } out_t;

endpackage
`default_nettype wire

// ===== rtl/stereo_output_limiter_stage.sv =====
// frame states: MONO, WID0, WID1, GL, GR, GR2, then in limit mode PEAK, DIV (only if the peak
//   exceeds the threshold), LG0, LG1, LG2, LL, LR, LR2; then CLAMP, VOL0, VOL1, VL, VR, VR2,
//   OUT; bypass goes to VOL0. in_ready only while idle, so output stalls also hold off input
// fade ramp command: busy in DIV (restoring divider, one quotient bit per cycle); jump applied in IDLE
// one shared 34x34 multiplier and one divider serve all steps
// reset (rst_n low, synchronous): config registers, limiter gain and fade return to defaults
`default_nettype none
module stereo_output_limiter_stage (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire sol_pkg::in_t                  in_data,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output sol_pkg::out_t                      out_data,
  input  wire logic                          cfg_we,
  input  wire logic [sol_pkg::CFG_AW-1:0]    cfg_addr,
  input  wire logic [sol_pkg::CFG_W-1:0]     cfg_wdata
);
  import sol_pkg::*;

  localparam logic [4:0] ST_IDLE  = 5'd0;
  localparam logic [4:0] ST_MONO  = 5'd1;
  localparam logic [4:0] ST_WID0  = 5'd2;
  localparam logic [4:0] ST_WID1  = 5'd3;
  localparam logic [4:0] ST_GL    = 5'd4;
  localparam logic [4:0] ST_GR    = 5'd5;
  localparam logic [4:0] ST_GR2   = 5'd6;
  localparam logic [4:0] ST_PEAK  = 5'd7;
  localparam logic [4:0] ST_DIV   = 5'd8;
  localparam logic [4:0] ST_LG0   = 5'd9;
  localparam logic [4:0] ST_LG1   = 5'd10;
  localparam logic [4:0] ST_LG2   = 5'd11;
  localparam logic [4:0] ST_LL    = 5'd12;
  localparam logic [4:0] ST_LR    = 5'd13;
  localparam logic [4:0] ST_LR2   = 5'd14;
  localparam logic [4:0] ST_CLAMP = 5'd15;
  localparam logic [4:0] ST_VOL0  = 5'd16;
  localparam logic [4:0] ST_VOL1  = 5'd17;
  localparam logic [4:0] ST_VL    = 5'd18;
  localparam logic [4:0] ST_VR    = 5'd19;
  localparam logic [4:0] ST_VR2   = 5'd20;
  localparam logic [4:0] ST_OUT   = 5'd21;

  function automatic logic signed [SAMPLE_W-1:0] sat_s(input logic signed [35:0] v);
    logic signed [35:0] hi;
    logic signed [35:0] lo;
    hi = (36'sd1 <<< (SAMPLE_W - 1)) - 36'sd1;
    lo = -(36'sd1 <<< (SAMPLE_W - 1));
    if (v > hi) begin
      sat_s = hi[SAMPLE_W-1:0];
    end else if (v < lo) begin
      sat_s = lo[SAMPLE_W-1:0];
    end else begin
      sat_s = v[SAMPLE_W-1:0];
    end
  endfunction

  function automatic logic [16:0] sat16(input logic [16:0] v);
    sat16 = (v > ONE16) ? ONE16 : v;
  endfunction

  logic [4:0]  st_r, st_nxt;
  logic [15:0] lgain_r, rgain_r, width_r;
  logic [3:0]  mode_r;
  logic [16:0] thr_r, volume_r;
  logic [23:0] attack_r, release_r;
  logic [24:0] lim_gain_r;
  logic [16:0] fade_level_r, fade_goal_r;
  logic signed [17:0] fade_step_r;

  logic signed [33:0] xl_r, xr_r, sum_r;
  logic signed [67:0] prod_r;
  logic signed [33:0] mul_a, mul_b;
  logic [24:0]  target_r;
  logic [23:0]  coef_r;
  logic [32:0]  g_r;
  logic [67:0]  acc_r;

  logic [31:0] rem_r, dvs_r;
  logic [24:0] dvd_r, quo_r;
  logic [4:0]  cnt_r;
  logic        div_ramp_r, div_neg_r;

  logic        out_valid_r;
  out_t        out_r;

  logic signed [67:0] ws, lp, rp, r12, r24, r32;
  logic [31:0] al, ar, peak;
  logic [23:0] thr_s;
  logic [32:0] dtry;
  logic        qbit;
  logic [31:0] rem_n;
  logic [24:0] quo_n;
  logic signed [17:0] fdiff;
  logic signed [18:0] fnext;
  logic [23:0] coef_sel;
  logic [24:0] one_m_coef;
  logic [67:0] gsum;

  assign in_ready  = (st_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    unique case (st_r)
      ST_WID0: begin
        mul_a = xl_r - xr_r;
        mul_b = {18'd0, width_r};
      end
      ST_GL: begin
        mul_a = xl_r;
        mul_b = {18'd0, lgain_r};
      end
      ST_GR: begin
        mul_a = xr_r;
        mul_b = {18'd0, rgain_r};
      end
      ST_LG0: begin
        mul_a = {10'd0, coef_sel};
        mul_b = {9'd0, lim_gain_r};
      end
      ST_LG1: begin
        mul_a = {9'd0, one_m_coef};
        mul_b = {9'd0, target_r};
      end
      ST_LL: begin
        mul_a = xl_r;
        mul_b = {9'd0, lim_gain_r};
      end
      ST_LR: begin
        mul_a = xr_r;
        mul_b = {9'd0, lim_gain_r};
      end
      ST_VOL0: begin
        mul_a = {17'd0, volume_r};
        mul_b = {17'd0, fade_level_r};
      end
      ST_VL: begin
        mul_a = xl_r;
        mul_b = {1'b0, g_r};
      end
      ST_VR: begin
        mul_a = xr_r;
        mul_b = {1'b0, g_r};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    ws    = 68'(sum_r) <<< 14;
    lp    = (ws + prod_r) >>> 15;
    rp    = (ws - prod_r) >>> 15;
    r12   = (prod_r + 68'sd2048) >>> 12;
    r24   = (prod_r + 68'sd8388608) >>> 24;
    r32   = (prod_r + 68'sd2147483648) >>> 32;
    al    = xl_r[33] ? 32'(-xl_r) : xl_r[31:0];
    ar    = xr_r[33] ? 32'(-xr_r) : xr_r[31:0];
    peak  = (al > ar) ? al : ar;
    thr_s = {thr_r, 7'd0};
    dtry  = {rem_r, dvd_r[24]};
    qbit  = (dtry >= {1'b0, dvs_r});
    rem_n = qbit ? 32'(dtry - {1'b0, dvs_r}) : dtry[31:0];
    quo_n = {quo_r[23:0], qbit};
    fdiff = $signed({1'b0, sat16(in_data.fade_target)}) - $signed({1'b0, fade_level_r});
    fnext = 19'(fade_level_r) + 19'(fade_step_r);
    coef_sel   = (target_r < lim_gain_r) ? attack_r : release_r;
    one_m_coef = ONE24 - {1'b0, coef_r};
    gsum  = (acc_r + 68'(prod_r) + 68'd8388608) >> 24;
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r         <= ST_IDLE;
      lgain_r      <= 16'd4096;
      rgain_r      <= 16'd4096;
      width_r      <= 16'd16384;
      mode_r       <= '0;
      thr_r        <= ONE16;
      attack_r     <= 24'd16543000;
      release_r    <= 24'd16771400;
      volume_r     <= ONE16;
      lim_gain_r   <= ONE24;
      fade_level_r <= ONE16;
      fade_goal_r  <= ONE16;
      fade_step_r  <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      st_r <= st_nxt;
      out_valid_r <= (st_r == ST_OUT) || (out_valid_r && !out_ready);
      if (cfg_we) begin
        unique case (cfg_addr)
          REG_LGAIN:   lgain_r   <= cfg_wdata[15:0];
          REG_RGAIN:   rgain_r   <= cfg_wdata[15:0];
          REG_WIDTH:   width_r   <= cfg_wdata[15:0];
          REG_MODE: begin
            mode_r <= cfg_wdata[3:0];
            if (!cfg_wdata[MODE_LIMIT]) begin
              lim_gain_r <= ONE24;
            end
          end
          REG_THR:     thr_r     <= sat16(cfg_wdata[16:0]);
          REG_ATTACK:  attack_r  <= cfg_wdata[23:0];
          REG_RELEASE: release_r <= cfg_wdata[23:0];
          REG_VOLUME:  volume_r  <= sat16(cfg_wdata[16:0]);
          default: ;
        endcase
      end
      if (st_r == ST_IDLE && in_valid) begin
        if (in_data.command == CMD_JUMP ||
            (in_data.command == CMD_RAMP && in_data.ramp_frames == 24'd0)) begin
          fade_level_r <= sat16(in_data.fade_target);
          fade_goal_r  <= sat16(in_data.fade_target);
          fade_step_r  <= '0;
        end else if (in_data.command == CMD_RAMP) begin
          fade_goal_r <= sat16(in_data.fade_target);
        end
      end
      if (st_r == ST_DIV && cnt_r == 5'd0) begin
        if (div_ramp_r) begin
          if (quo_n == 25'd0) begin
            fade_level_r <= fade_goal_r;
            fade_step_r  <= '0;
          end else begin
            fade_step_r <= div_neg_r ? -18'(quo_n) : 18'(quo_n);
          end
        end
      end
      if (st_r == ST_LG2) begin
        lim_gain_r <= gsum[24:0];
      end
      if (st_r == ST_OUT && (!out_valid_r || out_ready)) begin
        if (fade_step_r != 18'sd0) begin
          if ((fade_step_r > 0 && fnext >= $signed({2'b0, fade_goal_r})) ||
              (fade_step_r < 0 && fnext <= $signed({2'b0, fade_goal_r}))) begin
            fade_level_r <= fade_goal_r;
            fade_step_r  <= '0;
          end else begin
            fade_level_r <= fnext[16:0];
          end
        end
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (st_r)
      ST_IDLE: begin
        xl_r <= 34'(in_data.left_sample);
        xr_r <= 34'(in_data.right_sample);
        div_ramp_r <= 1'b1;
        div_neg_r  <= fdiff[17];
        rem_r <= '0;
        dvd_r <= 25'(fdiff[17] ? -fdiff : fdiff);
        dvs_r <= {8'd0, in_data.ramp_frames};
        quo_r <= '0;
        cnt_r <= 5'd24;
      end
      ST_MONO: begin
        if (mode_r[MODE_MONO]) begin
          xl_r <= (xl_r + xr_r) >>> 1;
          xr_r <= (xl_r + xr_r) >>> 1;
        end
      end
      ST_WID0: sum_r <= xl_r + xr_r;
      ST_WID1: begin
        if (mode_r[MODE_SWAP]) begin
          xl_r <= rp[33:0];
          xr_r <= lp[33:0];
        end else begin
          xl_r <= lp[33:0];
          xr_r <= rp[33:0];
        end
      end
      ST_GR:  xl_r <= r12[33:0];
      ST_GR2: xr_r <= r12[33:0];
      ST_PEAK: begin
        target_r   <= ONE24;
        div_ramp_r <= 1'b0;
        rem_r <= {9'd0, thr_s[23:1]};
        dvd_r <= {thr_s[0], 24'd0};
        dvs_r <= peak;
        quo_r <= '0;
        cnt_r <= 5'd24;
      end
      ST_DIV: begin
        rem_r <= rem_n;
        dvd_r <= {dvd_r[23:0], 1'b0};
        quo_r <= quo_n;
        cnt_r <= cnt_r - 5'd1;
        if (cnt_r == 5'd0) begin
          target_r <= quo_n;
        end
      end
      ST_LG0: coef_r <= coef_sel;
      ST_LG1: acc_r  <= prod_r;
      ST_LR:  xl_r <= r24[33:0];
      ST_LR2: xr_r <= r24[33:0];
      ST_CLAMP: begin
        xl_r <= 34'(sat_s(36'(xl_r)));
        xr_r <= 34'(sat_s(36'(xr_r)));
      end
      ST_VOL1: g_r <= prod_r[32:0];
      ST_VR:   xl_r <= 34'(sat_s(r32[35:0]));
      ST_VR2:  xr_r <= 34'(sat_s(r32[35:0]));
      ST_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_r.left_out  <= xl_r[SAMPLE_W-1:0];
          out_r.right_out <= xr_r[SAMPLE_W-1:0];
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_data.command == CMD_FRAME) begin
            st_nxt = mode_r[MODE_BYPASS] ? ST_VOL0 : ST_MONO;
          end else if (in_data.command == CMD_RAMP && in_data.ramp_frames != 24'd0) begin
            st_nxt = ST_DIV;
          end
        end
      end
      ST_MONO:  st_nxt = ST_WID0;
      ST_WID0:  st_nxt = ST_WID1;
      ST_WID1:  st_nxt = ST_GL;
      ST_GL:    st_nxt = ST_GR;
      ST_GR:    st_nxt = ST_GR2;
      ST_GR2:   st_nxt = mode_r[MODE_LIMIT] ? ST_PEAK : ST_CLAMP;
      ST_PEAK:  st_nxt = (peak > {8'd0, thr_s}) ? ST_DIV : ST_LG0;
      ST_DIV: begin
        if (cnt_r == 5'd0) begin
          st_nxt = div_ramp_r ? ST_IDLE : ST_LG0;
        end
      end
      ST_LG0:   st_nxt = ST_LG1;
      ST_LG1:   st_nxt = ST_LG2;
      ST_LG2:   st_nxt = ST_LL;
      ST_LL:    st_nxt = ST_LR;
      ST_LR:    st_nxt = ST_LR2;
      ST_LR2:   st_nxt = ST_CLAMP;
      ST_CLAMP: st_nxt = ST_VOL0;
      ST_VOL0:  st_nxt = ST_VOL1;
      ST_VOL1:  st_nxt = ST_VL;
      ST_VL:    st_nxt = ST_VR;
      ST_VR:    st_nxt = ST_VR2;
      ST_VR2:   st_nxt = ST_OUT;
      ST_OUT: begin
        if (!out_valid_r || out_ready) begin
          st_nxt = ST_IDLE;
        end
      end
      default:  st_nxt = ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/sol_checker.sv =====
`default_nettype none
module sol_checker (
  input wire logic                       clk,
  input wire logic                       rst_n,
  input wire logic                       in_valid,
  input wire logic                       in_ready,
  input wire sol_pkg::in_t               in_data,
  input wire logic                       out_valid,
  input wire logic                       out_ready,
  input wire sol_pkg::out_t              out_data
);
  import sol_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_frame_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_data.command == CMD_FRAME |=> !in_ready)
    else $error("ready after frame transaction");

  a_no_instant: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !$past(in_valid && in_ready))
    else $error("result right after input transaction");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind stereo_output_limiter_stage sol_checker u_sol_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
`default_nettype wire

// ===== verif/tb_stereo_output_limiter_stage.sv =====
module tb_stereo_output_limiter_stage;
  timeunit 1ns;
  timeprecision 1ps;
  import sol_pkg::*;

  localparam longint CYCLE_LIMIT = 1500000;
  localparam int SETTLE = 60;
  localparam int HOLD_CYCLES = 600;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;
  logic cfg_we = 1'b0;
  logic [CFG_AW-1:0] cfg_addr = '0;
  logic [CFG_W-1:0] cfg_wdata = '0;

  stereo_output_limiter_stage u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  // shadow of registers and processing state
  longint lgain, rgain, width_q14, thr, atk, rel, vol;
  logic [3:0] mode;
  longint lim_gain, fade_lvl, fade_stp, fade_goal;

  out_t frame_q[$];
  int errors = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  int hold_cnt = 0;
  logic hold_req = 1'b0;
  longint cycles = 0;

  initial forever #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_stereo_output_limiter_stage: errors");
      $finish;
    end
  end

  function automatic longint sat16(longint v);
    return (v > 65536) ? 65536 : v;
  endfunction

  function automatic longint clamp_s(longint x);
    if (x > 64'sd8388607) return 64'sd8388607;
    if (x < -64'sd8388608) return -64'sd8388608;
    return x;
  endfunction

  function automatic longint rnd_shift(longint x, int n);
    return (x + (longint'(1) <<< (n - 1))) >>> n;
  endfunction

  function automatic void fade_jump(longint tgt);
    fade_lvl = sat16(tgt);
    fade_goal = fade_lvl;
    fade_stp = 0;
  endfunction

  // returns 1 when the transaction yields an output frame
  function automatic bit process_frame(input in_t it, output out_t res);
    longint l, r, sum, diff, t, al, ar, peak, thr_s, target, coef, g32;
    res = '0;
    if (it.command == CMD_JUMP) begin
      fade_jump(it.fade_target);
      return 0;
    end
    if (it.command == CMD_RAMP) begin
      if (it.ramp_frames == 0) begin
        fade_jump(it.fade_target);
        return 0;
      end
      fade_goal = sat16(it.fade_target);
      fade_stp = (fade_goal - fade_lvl) / longint'(it.ramp_frames);
      if (fade_stp == 0) fade_lvl = fade_goal;
      return 0;
    end
    if (it.command != CMD_FRAME) return 0;
    l = longint'(it.left_sample);
    r = longint'(it.right_sample);
    if (!mode[MODE_BYPASS]) begin
      if (mode[MODE_MONO]) begin
        l = (l + r) >>> 1;
        r = l;
      end
      sum = (l + r) * 16384;
      diff = (l - r) * width_q14;
      l = (sum + diff) >>> 15;
      r = (sum - diff) >>> 15;
      if (mode[MODE_SWAP]) begin
        t = l; l = r; r = t;
      end
      l = rnd_shift(l * lgain, 12);
      r = rnd_shift(r * rgain, 12);
      if (mode[MODE_LIMIT]) begin
        al = (l < 0) ? -l : l;
        ar = (r < 0) ? -r : r;
        peak = (al > ar) ? al : ar;
        thr_s = (sat16(thr) << 23) >> 16;
        target = longint'(ONE24);
        if (peak > thr_s) target = (thr_s << 24) / peak;
        coef = (target < lim_gain) ? atk : rel;
        lim_gain = (coef * lim_gain + (longint'(ONE24) - coef) * target + (1 << 23)) >>> 24;
        l = rnd_shift(l * lim_gain, 24);
        r = rnd_shift(r * lim_gain, 24);
      end
      l = clamp_s(l);
      r = clamp_s(r);
    end
    g32 = sat16(vol) * fade_lvl;
    l = clamp_s(rnd_shift(l * g32, 32));
    r = clamp_s(rnd_shift(r * g32, 32));
    if (fade_stp != 0) begin
      fade_lvl = fade_lvl + fade_stp;
      if ((fade_stp > 0 && fade_lvl >= fade_goal) || (fade_stp < 0 && fade_lvl <= fade_goal)) begin
        fade_lvl = fade_goal;
        fade_stp = 0;
      end
    end
    res.left_out = l[SAMPLE_W-1:0];
    res.right_out = r[SAMPLE_W-1:0];
    return 1;
  endfunction

  // result checker
  always @(posedge clk) begin
    out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (frame_q.size() == 0) begin
        $display("%0t unexpected frame: left %0d right %0d", $time,
                 out_data.left_out, out_data.right_out);
        errors++;
      end else begin
        want = frame_q.pop_front();
        if (want.left_out !== out_data.left_out) begin
          $display("%0t left_out mismatch: expected %0d actual %0d", $time,
                   want.left_out, out_data.left_out);
          errors++;
        end
        if (want.right_out !== out_data.right_out) begin
          $display("%0t right_out mismatch: expected %0d actual %0d", $time,
                   want.right_out, out_data.right_out);
          errors++;
        end
      end
    end
  end

  // receiver stall generator
  always @(posedge clk) begin
    if (hold_req) begin
      out_ready <= 1'b0;
      hold_cnt <= HOLD_CYCLES;
    end else if (hold_cnt > 0) begin
      out_ready <= 1'b0;
      hold_cnt <= hold_cnt - 1;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  task automatic send_item(input in_t it);
    int gap;
    out_t res;
    gap = ($urandom_range(0, 99) < idle_pct) ? $urandom_range(1, 8) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
    if (process_frame(it, res)) frame_q.push_back(res);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (frame_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_AW-1:0] a, input longint d);
    logic [CFG_W-1:0] v;
    v = d[CFG_W-1:0];
    cfg_we <= 1'b1;
    cfg_addr <= a;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (a)
      REG_LGAIN: lgain = v[15:0];
      REG_RGAIN: rgain = v[15:0];
      REG_WIDTH: width_q14 = v[15:0];
      REG_MODE: begin
        mode = v[3:0];
        if (!mode[MODE_LIMIT]) lim_gain = longint'(ONE24);
      end
      REG_THR: thr = v[16:0];
      REG_ATTACK: atk = v[23:0];
      REG_RELEASE: rel = v[23:0];
      REG_VOLUME: vol = v[16:0];
      default: ;
    endcase
  endtask

  function automatic in_t mk_frame(longint l, longint r);
    in_t it;
    it = '0;
    it.command = CMD_FRAME;
    it.left_sample = l[SAMPLE_W-1:0];
    it.right_sample = r[SAMPLE_W-1:0];
    return it;
  endfunction

  function automatic in_t mk_fade(logic [1:0] cmd, longint tgt, longint frames);
    in_t it;
    it = '0;
    it.command = cmd;
    it.fade_target = tgt[16:0];
    it.ramp_frames = frames[23:0];
    return it;
  endfunction

  function automatic longint pick(longint lo, longint hi);
    case ($urandom_range(0, 3))
      0: return lo;
      1: return hi;
      default: return lo + ($urandom() % (hi - lo + 1));
    endcase
  endfunction

  function automatic in_t rand_item();
    in_t it;
    int sel;
    logic [95:0] raw;
    raw = {$urandom(), $urandom(), $urandom()};
    it = raw[$bits(in_t)-1:0];
    sel = $urandom_range(0, 99);
    if (sel < 85) begin
      it.command = CMD_FRAME;
      if ($urandom_range(0, 3) == 0) begin
        it.left_sample = $signed(24'($urandom_range(0, 4095) - 2048));
        it.right_sample = $signed(24'($urandom_range(0, 4095) - 2048));
      end
    end else if (sel < 92) begin
      it.command = CMD_RAMP;
      if ($urandom_range(0, 7) != 0) it.ramp_frames = 24'($urandom_range(0, 40));
    end else if (sel < 96) begin
      it.command = CMD_JUMP;
    end else begin
      it.command = CMD_UNUSED;
    end
    return it;
  endfunction

  task automatic cfg_random();
    cfg_write(REG_LGAIN, pick(0, 65535));
    cfg_write(REG_RGAIN, pick(0, 65535));
    cfg_write(REG_WIDTH, pick(0, 65535));
    cfg_write(REG_MODE, $urandom_range(0, 15));
    cfg_write(REG_THR, pick(0, 16777215));
    cfg_write(REG_ATTACK, pick(0, 16777215));
    cfg_write(REG_RELEASE, pick(0, 16777215));
    cfg_write(REG_VOLUME, ($urandom_range(0, 3) == 0) ? pick(0, 16777215) : pick(0, 65536));
    cfg_write(4'($urandom_range(8, 15)), $urandom());
  endtask

  task automatic test_directed();
    send_item(mk_frame(8388607, 8388607));
    send_item(mk_frame(-8388608, -8388608));
    send_item(mk_frame(8388607, -8388608));
    send_item(mk_fade(CMD_UNUSED, 65536, 5));
    send_item(mk_fade(CMD_JUMP, 131071, 0));
    send_item(mk_frame(1234567, -7654321));
    send_item(mk_fade(CMD_RAMP, 0, 0));
    send_item(mk_fade(CMD_RAMP, 65536, 4));
    repeat (5) send_item(mk_frame(4000000, -4000000));
    send_item(mk_fade(CMD_JUMP, 100, 0));
    send_item(mk_fade(CMD_RAMP, 120, 1000));
    send_item(mk_frame(8388607, 1));
    send_item(mk_fade(CMD_JUMP, 65536, 0));
    drain();
    cfg_write(REG_MODE, 4'b0111);
    cfg_write(REG_THR, 3277);
    cfg_write(REG_WIDTH, 32768);
    send_item(mk_frame(8388607, -8388608));
    send_item(mk_frame(-8388608, 8388607));
    send_item(mk_frame(100, 200));
    drain();
    cfg_write(REG_MODE, 4'b1000);
    send_item(mk_frame(8388607, -8388608));
    send_item(mk_frame(-1, 0));
    drain();
    cfg_write(REG_MODE, 4'b0000);
    cfg_write(REG_THR, 65536);
    cfg_write(REG_WIDTH, 16384);
  endtask

  task automatic test_backpressure();
    cfg_write(REG_MODE, 4'b0100);
    hold_req <= 1'b1;
    @(posedge clk);
    hold_req <= 1'b0;
    repeat (20) send_item(rand_item());
    drain();
  endtask

  task automatic test_random_phase(input int sidle, input int rstall, input int n);
    idle_pct = sidle;
    stall_pct = rstall;
    repeat (2) begin
      drain();
      cfg_random();
      repeat (n) send_item(rand_item());
    end
    drain();
  endtask

  initial begin
    lgain = 4096; rgain = 4096; width_q14 = 16384; mode = '0;
    thr = 65536; atk = 16543000; rel = 16771400; vol = 65536;
    lim_gain = longint'(ONE24); fade_lvl = 65536; fade_stp = 0; fade_goal = 65536;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_backpressure();
    test_random_phase(0, 0, 225);
    test_random_phase(60, 0, 225);
    test_random_phase(0, 60, 225);
    test_random_phase(18, 18, 225);
    drain();
    if (errors == 0 && frame_q.size() == 0) begin
      $display("tb_stereo_output_limiter_stage: clean");
    end else begin
      $display("tb_stereo_output_limiter_stage: errors");
    end
    $finish;
  end

endmodule
